/* sv/glos_pkg.sv */
// Shared constants, types and codes for the grid line-of-sight block.
package glos_pkg;

  // Map geometry
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int MAP_CELLS   = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_AW     = $clog2(MAP_CELLS);

  // Field widths
  localparam int COORD_W = 6;
  localparam int MW_W    = 7;
  // y * map_width + x always fits here
  localparam int LIN_AW  = COORD_W + MW_W + 1;
  // Bresenham error term and its double
  localparam int ERR_W   = 2 * COORD_W + 2;
  localparam int E2_W    = ERR_W + 1;
  // Step count, up to twice the coordinate range
  localparam int STEP_W  = COORD_W + 1;

  localparam logic [MW_W-1:0] MAP_WIDTH_RST = MW_W'(64);

  // Item codes
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } act_e;

  // Walker sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } walk_state_e;

  // One map access per cycle: a cell write or a cell read
  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               wr_data;
  } map_req_t;

endpackage

/* sv/glos_in_if.sv */
// Input word channel: map writes and line-of-sight queries.
interface glos_in_if;
  import glos_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [COORD_W-1:0] from_x;
  logic [COORD_W-1:0] from_y;
  logic [COORD_W-1:0] to_x;
  logic [COORD_W-1:0] to_y;
  logic               blocked;

  modport source (output valid, action, from_x, from_y, to_x, to_y, blocked,
                  input ready);
  modport sink   (input valid, action, from_x, from_y, to_x, to_y, blocked,
                  output ready);
endinterface

/* sv/glos_out_if.sv */
// Result word channel: one visibility bit per query.
interface glos_out_if;
  logic valid;
  logic ready;
  logic has_sight;

  modport source (output valid, has_sight, input ready);
  modport sink   (input valid, has_sight, output ready);
endinterface

/* sv/glos_cfg_if.sv */
// Configuration write channel: map row length.
interface glos_cfg_if;
  import glos_pkg::*;

  logic            valid;
  logic            ready;
  logic [MW_W-1:0] map_width;

  modport source (output valid, map_width, input ready);
  modport sink   (input valid, map_width, output ready);
endinterface

/* sv/grid_line_of_sight.sv */
// Top level: grid line-of-sight block with occupancy map and line walker.
//
//   channel  dir  payload                                        notes
//   in_i     in   action, from_x, from_y, to_x, to_y, blocked    write or query
//   out_o    out  has_sight                                      one word per query
//   cfg_i    in   map_width                                      always ready
//
// A write word is applied to the map in the cycle it is taken.
// A query walks the line with the single map port doing one cell read per cycle
// along the line.
// After reset the map is swept to open, one cell a cycle over all MAP_CELLS = 4096 cells,
// with in_i.ready low; configuration writes are taken during the sweep.
// A pending result in out_o does not stop new words; a finished query waits in
// its last state only while the previous result is still unread.
module grid_line_of_sight (
  input  logic        clk_i,
  input  logic        rst_ni,
  glos_in_if.sink     in_i,
  glos_out_if.source  out_o,
  glos_cfg_if.sink    cfg_i
);
  import glos_pkg::*;

  logic [MW_W-1:0] map_width_q;
  map_req_t        map_req;
  logic            clr_busy;
  logic            rd_blocked;

  // Map width register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q <= MAP_WIDTH_RST;
    end else if (cfg_i.valid) begin
      map_width_q <= cfg_i.map_width;
    end
  end

  glos_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .clr_busy_i   (clr_busy),
    .rd_blocked_i (rd_blocked),
    .req_o        (map_req)
  );

  glos_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .map_width_i  (map_width_q),
    .req_i        (map_req),
    .clr_busy_o   (clr_busy),
    .rd_blocked_o (rd_blocked)
  );

endmodule

/* sv/glos_map.sv */
// Occupancy map: one-bit synchronous memory with address mapping and a clear sweep.
module glos_map (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [glos_pkg::MW_W-1:0] map_width_i,
  input  glos_pkg::map_req_t       req_i,
  output logic                     clr_busy_o,
  output logic                     rd_blocked_o
);
  import glos_pkg::*;

  logic               mem_q [MAP_CELLS];
  logic [LIN_AW-1:0]  lin_addr;
  logic [CELL_AW-1:0] cell_idx;
  logic               in_range;
  logic               rd_q;
  logic               rng_q;
  logic               clr_busy_q, clr_busy_d;
  logic [CELL_AW-1:0] clr_idx_q, clr_idx_d;

  // Linear address and bounds check
  assign lin_addr = LIN_AW'(req_i.y) * LIN_AW'(map_width_i) + LIN_AW'(req_i.x);
  assign in_range = ({{(32-LIN_AW){1'b0}}, lin_addr} < 32'(MAP_CELLS));
  assign cell_idx = CELL_AW'(lin_addr);

  // Clear sweep after reset, one cell a cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + CELL_AW'(1);
      if (clr_idx_q == CELL_AW'(MAP_CELLS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  // Memory port: sweep write, cell write or cell read
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_idx_q] <= 1'b0;
    end else if (req_i.wr_en && in_range) begin
      mem_q[cell_idx] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q  <= mem_q[cell_idx];
      rng_q <= in_range;
    end
  end

  // Out-of-map cells read as open
  assign rd_blocked_o = rd_q & rng_q;
  assign clr_busy_o   = clr_busy_q;

endmodule

/* sv/glos_walker.sv */
// Line walker: takes words, steps the four-connected line and folds map reads.
module glos_walker (
  input  logic               clk_i,
  input  logic               rst_ni,
  glos_in_if.sink            in_i,
  glos_out_if.source         out_o,
  input  logic               clr_busy_i,
  input  logic               rd_blocked_i,
  output glos_pkg::map_req_t req_o
);
  import glos_pkg::*;

  walk_state_e         state_q, state_d;
  logic [COORD_W-1:0]  x_q, y_q;
  logic [COORD_W-1:0]  dx_q, dy_q;
  logic                neg_x_q, neg_y_q;
  logic signed [ERR_W-1:0] err_q;
  logic [STEP_W-1:0]   steps_q;
  logic                clear_q;
  logic                rd_pend_q;
  logic                out_valid_q;
  logic                has_sight_q;

  logic                accept;
  logic                is_query;
  logic                load_out;
  logic [COORD_W-1:0]  dx_in, dy_in;
  logic signed [E2_W-1:0] e2;
  logic signed [E2_W-1:0] neg_dy;
  logic                move_x;
  logic                in_ready;
  logic                at_end;

  assign accept   = in_i.valid && in_ready;
  assign is_query = (act_e'(in_i.action) == ACT_QUERY);
  assign at_end   = (steps_q == '0);

  // Distances from the incoming word
  assign dx_in = (in_i.from_x > in_i.to_x) ? in_i.from_x - in_i.to_x
                                           : in_i.to_x - in_i.from_x;
  assign dy_in = (in_i.from_y > in_i.to_y) ? in_i.from_y - in_i.to_y
                                           : in_i.to_y - in_i.from_y;

  // Step decision: x moves when 2*err > -dy
  assign e2     = {err_q, 1'b0};
  assign neg_dy = -$signed({{(E2_W-COORD_W){1'b0}}, dy_q});
  assign move_x = (e2 > neg_dy);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (at_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake, map requests
  always_comb begin
    in_ready      = 1'b0;
    load_out      = 1'b0;
    req_o.wr_en   = 1'b0;
    req_o.rd_en   = 1'b0;
    req_o.x       = x_q;
    req_o.y       = y_q;
    req_o.wr_data = in_i.blocked;
    case (state_q)
      ST_IDLE: begin
        in_ready    = !clr_busy_i;
        req_o.x     = in_i.from_x;
        req_o.y     = in_i.from_y;
        req_o.wr_en = accept && !is_query;
      end
      ST_WALK:  req_o.rd_en = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  load_out = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.has_sight = has_sight_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= req_o.rd_en;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept && is_query) begin
      x_q     <= in_i.from_x;
      y_q     <= in_i.from_y;
      dx_q    <= dx_in;
      dy_q    <= dy_in;
      neg_x_q <= !(in_i.from_x < in_i.to_x);
      neg_y_q <= !(in_i.from_y < in_i.to_y);
      err_q   <= $signed({{(ERR_W-COORD_W){1'b0}}, dx_in})
               - $signed({{(ERR_W-COORD_W){1'b0}}, dy_in});
      steps_q <= STEP_W'(dx_in) + STEP_W'(dy_in);
      clear_q <= 1'b1;
    end else begin
      if (state_q == ST_WALK && !at_end) begin
        steps_q <= steps_q - STEP_W'(1);
        if (move_x) begin
          err_q <= err_q - $signed({{(ERR_W-COORD_W){1'b0}}, dy_q});
          x_q   <= neg_x_q ? x_q - COORD_W'(1) : x_q + COORD_W'(1);
        end else begin
          err_q <= err_q + $signed({{(ERR_W-COORD_W){1'b0}}, dx_q});
          y_q   <= neg_y_q ? y_q - COORD_W'(1) : y_q + COORD_W'(1);
        end
      end
      // Fold the cell read issued last cycle
      if (rd_pend_q && rd_blocked_i) begin
        clear_q <= 1'b0;
      end
    end
    if (load_out) begin
      has_sight_q <= clear_q;
    end
  end

endmodule
